>>> design/satd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_pkg
// Shared constants, codes and types of the saturation trend detector.
// ----------------------------------------------------------------------------
package satd_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int FAST_FAIL_FACTOR = 3;

    localparam int FLITS_W  = 16;
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 24;
    localparam int WSIZE_W  = 7;
    localparam int LIMIT_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FLIT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 2'd2;

    localparam logic [1:0] VERDICT_NONE      = 2'd0;
    localparam logic [1:0] VERDICT_WARMED    = 2'd1;
    localparam logic [1:0] VERDICT_SATURATED = 2'd2;

    localparam logic [FLITS_W-1:0] FLIT_INTERVAL_RST = 16'd1024;
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST   = 7'd5;
    localparam logic [LIMIT_W-1:0] ATTEMPT_LIMIT_RST = 8'd10;

    // Result of one pass over the window.
    typedef struct packed {
        logic               done;
        logic               positive;
        logic [VALUE_W-1:0] max_value;
    } t_stat_res;

endpackage

>>> design/saturation_trend_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturation_trend_detector
// Samples in-flight flit counts per flit interval into a window memory and
// decides warmed or saturated from the regression slope of the window.
// ----------------------------------------------------------------------------
// Saturation comes from a rising slope at the attempt limit or from fast fail.
// A beat that takes no sample goes straight to the response; a sample passes
// the remainder unit and the window write and, once the window is full, walks
// it, one memory read a cycle. One beat at a time: new beats only in S_IDLE.
// Reset: synchronous, active low; clears all control state, the window
// memory is not cleared and only written entries are read.
module saturation_trend_detector #(
    parameter int WINDOW_MAX = satd_pkg::WINDOW_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // exited_flits[15:0], sample_time[47:16], enroute_flits[71:48]
    input  logic [71:0]                     i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // verdict[1:0], sample_taken[2], detector_done[3], zero[7:4]
    output logic [7:0]                      o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [satd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [satd_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int SW = (CW > satd_pkg::WSIZE_W) ? CW : satd_pkg::WSIZE_W;
    localparam int FW = satd_pkg::FLITS_W;
    localparam int TW = satd_pkg::TIME_W;
    localparam int VW = satd_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_WRITE, S_WALK, S_RESP
    } t_state;

    t_state                        r_state;
    logic [FW-1:0]                 r_interval;
    logic [satd_pkg::WSIZE_W-1:0]  r_wsize_cfg;
    logic [satd_pkg::LIMIT_W-1:0]  r_limit;
    logic [FW-1:0]                 r_acc;
    logic [FW:0]                   r_total;
    logic [CW-1:0]                 r_fill;
    logic [AW-1:0]                 r_wp;
    logic [VW-1:0]                 r_ref;
    logic                          r_ref_valid;
    logic [satd_pkg::LIMIT_W-1:0]  r_attempt;
    logic                          r_finished;
    logic                          r_fast_sat;
    logic [TW-1:0]                 r_time;
    logic [VW-1:0]                 r_value;
    logic [1:0]                    r_verdict;
    logic                          r_taken;
    logic                          r_out_valid;
    logic [7:0]                    r_out_data;
    logic                          r_div_start;
    logic                          r_stat_start;

    logic [FW-1:0]                 interval;
    logic [SW-1:0]                 ws_ext;
    logic [SW-1:0]                 ws_eff;
    logic [CW-1:0]                 wsize;
    logic [FW:0]                   total;
    logic                          div_done;
    logic [FW-1:0]                 div_rem;
    logic [CW-1:0]                 wp_ext;
    logic [AW-1:0]                 wp_base;
    logic [CW-1:0]                 wp_inc;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [TW+VW-1:0]              ram_rdata;
    logic [CW-1:0]                 fill_nx;
    logic [VW+1:0]                 ref_lim;
    satd_pkg::t_stat_res           stat;
    logic                          sat_now;
    logic [1:0]                    verdict_now;

    assign interval = (r_interval == '0) ? FW'(1) : r_interval;
    assign ws_ext   = SW'(r_wsize_cfg);
    always_comb begin
        if (ws_ext == '0) begin
            ws_eff = SW'(1);
        end else if (ws_ext > SW'(WINDOW_MAX)) begin
            ws_eff = SW'(WINDOW_MAX);
        end else begin
            ws_eff = ws_ext;
        end
    end
    assign wsize = ws_eff[CW-1:0];
    assign total = {1'b0, r_acc} + {1'b0, i_s_tdata[FW-1:0]};

    // Ring slot once the window is full.
    assign wp_ext  = CW'(r_wp);
    assign wp_base = (wp_ext >= wsize) ? '0 : r_wp;
    assign wp_inc  = CW'(wp_base) + CW'(1);

    assign ram_we    = (r_state == S_WRITE);
    assign ram_waddr = (r_fill < wsize) ? r_fill[AW-1:0] : wp_base;
    assign fill_nx   = (r_fill < wsize) ? r_fill + CW'(1) : r_fill;
    assign ref_lim   = (VW+2)'(r_ref) * (VW+2)'(satd_pkg::FAST_FAIL_FACTOR);

    assign sat_now = r_fast_sat
                   || (stat.positive && (r_attempt == r_limit));
    always_comb begin
        if (sat_now) begin
            verdict_now = satd_pkg::VERDICT_SATURATED;
        end else if (!stat.positive) begin
            verdict_now = satd_pkg::VERDICT_WARMED;
        end else begin
            verdict_now = satd_pkg::VERDICT_NONE;
        end
    end

    satd_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_total),
        .i_den   (interval),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    satd_ram #(
        .WIDTH (TW + VW),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_time, r_value}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    satd_stats #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_stat_start),
        .i_count    (wsize),
        .o_raddr    (ram_raddr),
        .i_rd_time  (ram_rdata[TW+VW-1:VW]),
        .i_rd_value (ram_rdata[VW-1:0]),
        .o_res      (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_interval   <= satd_pkg::FLIT_INTERVAL_RST;
            r_wsize_cfg  <= satd_pkg::WINDOW_SIZE_RST;
            r_limit      <= satd_pkg::ATTEMPT_LIMIT_RST;
            r_acc        <= '0;
            r_fill       <= '0;
            r_wp         <= '0;
            r_ref        <= '0;
            r_ref_valid  <= 1'b0;
            r_attempt    <= '0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_div_start  <= 1'b0;
            r_stat_start <= 1'b0;
        end else begin
            r_div_start  <= 1'b0;
            r_stat_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    satd_pkg::CFG_FLIT_INTERVAL: r_interval  <= i_cfg_data;
                    satd_pkg::CFG_WINDOW_SIZE:
                        r_wsize_cfg <= i_cfg_data[satd_pkg::WSIZE_W-1:0];
                    satd_pkg::CFG_ATTEMPT_LIMIT:
                        r_limit <= i_cfg_data[satd_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_RESP && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {4'b0000, r_finished, r_taken, r_verdict};
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_time  <= i_s_tdata[FW+TW-1:FW];
                        r_value <= i_s_tdata[FW+TW+VW-1:FW+TW];
                        r_verdict <= satd_pkg::VERDICT_NONE;
                        r_taken   <= 1'b0;
                        if (r_finished) begin
                            r_state <= S_RESP;
                        end else if (total < {1'b0, interval}) begin
                            r_acc   <= total[FW-1:0];
                            r_state <= S_RESP;
                        end else begin
                            r_total     <= total;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_acc   <= div_rem;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_taken <= 1'b1;
                    r_fill  <= fill_nx;
                    if (r_fill >= wsize) begin
                        r_wp <= (wp_inc == wsize) ? '0 : wp_inc[AW-1:0];
                    end
                    if (fill_nx >= wsize) begin
                        r_fast_sat   <= r_ref_valid && ({2'b00, r_value} > ref_lim);
                        r_attempt    <= r_attempt + 8'd1;
                        r_stat_start <= 1'b1;
                        r_state      <= S_WALK;
                    end else begin
                        r_state <= S_RESP;
                    end
                end
                S_WALK: begin
                    if (stat.done) begin
                        if (!r_ref_valid) begin
                            r_ref       <= stat.max_value;
                            r_ref_valid <= 1'b1;
                        end
                        r_verdict <= verdict_now;
                        if (verdict_now != satd_pkg::VERDICT_NONE) begin
                            r_finished <= 1'b1;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

    a_verdict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != satd_pkg::VERDICT_NONE) |-> o_m_tdata[3])
        else $error("verdict without done flag");

    a_ref_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_valid |-> (r_fill != '0))
        else $error("reference latched with empty window");
`endif

endmodule

>>> design/satd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module satd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/satd_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_mod
// Restoring remainder unit: 17-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module satd_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [satd_pkg::FLITS_W:0]  i_num,
    input  logic [satd_pkg::FLITS_W-1:0] i_den,
    output logic                        o_done,
    output logic [satd_pkg::FLITS_W-1:0] o_rem
);

    localparam int NW = satd_pkg::FLITS_W + 1;

    logic                 r_busy;
    logic [4:0]           r_cnt;
    logic [NW-1:0]        r_num;
    logic [NW-1:0]        r_rem;
    logic [NW-2:0]        r_den;
    logic                 r_done;
    logic [NW-1:0]        rem_sh;
    logic [NW-1:0]        rem_nx;

    always_comb begin
        rem_sh = {r_rem[NW-2:0], r_num[NW-1]};
        if (rem_sh >= {1'b0, r_den}) begin
            rem_nx = rem_sh - {1'b0, r_den};
        end else begin
            rem_nx = rem_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= rem_nx;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[NW-2:0];

endmodule

>>> design/satd_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satd_stats
// Walks the window memory, forms the regression sums and the largest value,
// then decides the sign of n*sum(t*v) - sum(t)*sum(v).
// ----------------------------------------------------------------------------
module satd_stats #(
    parameter int WINDOW_MAX = satd_pkg::WINDOW_MAX_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [$clog2(WINDOW_MAX+1)-1:0]        i_count,
    output logic [$clog2(WINDOW_MAX)-1:0]          o_raddr,
    input  logic [satd_pkg::TIME_W-1:0]            i_rd_time,
    input  logic [satd_pkg::VALUE_W-1:0]           i_rd_value,
    output satd_pkg::t_stat_res                    o_res
);

    localparam int CW  = $clog2(WINDOW_MAX + 1);
    localparam int AW  = $clog2(WINDOW_MAX);
    localparam int ST  = satd_pkg::TIME_W + CW;
    localparam int SV  = satd_pkg::VALUE_W + CW;
    localparam int PTV = satd_pkg::TIME_W + satd_pkg::VALUE_W;
    localparam int STV = PTV + CW;
    localparam int H   = (SV + 1) / 2;
    localparam int PW  = ST + SV;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_MUL0, S_MUL1, S_CMP
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_n;
    logic [CW-1:0]                r_issue;
    logic                         r_v1;
    logic                         r_v2;
    logic [PTV-1:0]               r_p;
    logic [satd_pkg::TIME_W-1:0]  r_t2;
    logic [satd_pkg::VALUE_W-1:0] r_val2;
    logic [ST-1:0]                r_st;
    logic [SV-1:0]                r_sv;
    logic [STV-1:0]               r_stv;
    logic [satd_pkg::VALUE_W-1:0] r_max;
    logic [PW-1:0]                r_pa;
    logic [PW-1:0]                r_pb0;
    logic [PW-1:0]                r_pb1;
    logic                         r_done;
    logic                         r_pos;
    logic [PW-1:0]                pb;

    assign pb = r_pb0 + (r_pb1 << H);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
            r_issue <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_RUN;
                        r_issue <= '0;
                    end
                end
                S_RUN: begin
                    if (r_issue < r_n) begin
                        r_issue <= r_issue + CW'(1);
                        r_v1    <= 1'b1;
                    end else begin
                        r_v1 <= 1'b0;
                        if (!r_v1 && !r_v2) begin
                            r_state <= S_MUL0;
                        end
                    end
                    r_v2 <= r_v1;
                end
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: r_state <= S_CMP;
                S_CMP: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (i_start && r_state == S_IDLE) begin
            r_n   <= i_count;
            r_st  <= '0;
            r_sv  <= '0;
            r_stv <= '0;
            r_max <= '0;
        end
        if (r_v1) begin
            r_p    <= i_rd_time * i_rd_value;
            r_t2   <= i_rd_time;
            r_val2 <= i_rd_value;
        end
        if (r_v2) begin
            r_st  <= r_st + ST'(r_t2);
            r_sv  <= r_sv + SV'(r_val2);
            r_stv <= r_stv + STV'(r_p);
            if (r_val2 > r_max) begin
                r_max <= r_val2;
            end
        end
        // The wide product sum(t)*sum(v) is split over the halves of sum(v), in S_MUL0 and S_MUL1.
        if (r_state == S_MUL0) begin
            r_pa  <= PW'(r_stv) * PW'(r_n);
            r_pb0 <= PW'(r_st) * PW'(r_sv[H-1:0]);
        end
        if (r_state == S_MUL1) begin
            r_pb1 <= PW'(r_st) * PW'(r_sv[SV-1:H]);
        end
        if (r_state == S_CMP) begin
            r_pos <= r_pa > pb;
        end
    end

    assign o_raddr         = r_issue[AW-1:0];
    assign o_res.done      = r_done;
    assign o_res.positive  = r_pos;
    assign o_res.max_value = r_max;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the saturation trend detector. A queue of message-exit
// beats and register writes feeds a clocked driver. A local model of the
// sampling window, the fast-fail reference and the slope sign predicts every
// result beat, and a clocked monitor checks each one against that prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 500;
    localparam int LONG_HOLD_AT  = 350;

    typedef struct {
        bit          is_cfg;
        bit          no_write;
        bit          rel_limit;
        logic [1:0]  idx;
        logic [15:0] data;
        logic [15:0] flits;
        logic [31:0] stamp;
        logic [23:0] enroute;
        int          gap;
    } t_job;

    typedef struct packed {
        logic [3:0] pad;
        logic       done;
        logic       taken;
        logic [1:0] verdict;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] s_tdata = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    saturation_trend_detector u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state of the detector.
    logic [31:0] win_time [satd_pkg::WINDOW_MAX_DEF];
    logic [23:0] win_val  [satd_pkg::WINDOW_MAX_DEF];
    int          flit_acc = 0;
    int          wr_pos = 0;
    int          fill_cnt = 0;
    int          ref_level = 0;
    bit          ref_valid = 0;
    logic [7:0]  attempts = '0;
    bit          stopped = 0;
    logic [15:0] flit_interval = satd_pkg::FLIT_INTERVAL_RST;
    logic [6:0]  window_size = satd_pkg::WINDOW_SIZE_RST;
    logic [7:0]  attempt_limit = satd_pkg::ATTEMPT_LIMIT_RST;

    t_job     jobs[$];
    t_outcome verdicts_due[$];
    int       mismatches = 0;
    bit       burst_tx = 0;
    bit       burst_rx = 0;
    int       trend_k = 0;

    // Sign of the least-squares slope numerator over window entries 0..n-1.
    function automatic int slope_sign(int n);
        logic signed [127:0] acc;
        logic signed [127:0] dt;
        logic signed [127:0] dv;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                dt = $signed({96'd0, win_time[i]}) - $signed({96'd0, win_time[j]});
                dv = $signed({104'd0, win_val[i]}) - $signed({104'd0, win_val[j]});
                acc += dt * dv;
            end
        end
        if (acc < 0) return -1;
        if (acc == 0) return 0;
        return 1;
    endfunction

    function automatic t_outcome detector_step(logic [15:0] flits, logic [31:0] stamp,
                                               logic [23:0] enroute);
        t_outcome res;
        int ival, ws, total, slot, mx;
        bit warm, sat;
        res = '0;
        warm = 0;
        sat = 0;
        if (stopped) begin
            res.done = 1'b1;
            return res;
        end
        ival = (flit_interval == 0) ? 1 : int'(flit_interval);
        ws = (window_size == 0) ? 1 : int'(window_size);
        if (ws > satd_pkg::WINDOW_MAX_DEF) ws = satd_pkg::WINDOW_MAX_DEF;
        total = flit_acc + int'(flits);
        if (total >= ival) begin
            flit_acc = total % ival;
            res.taken = 1'b1;
            if (fill_cnt < ws) begin
                slot = fill_cnt;
                fill_cnt++;
            end else begin
                if (wr_pos >= ws) wr_pos = 0;
                slot = wr_pos;
                wr_pos = (wr_pos + 1) % ws;
            end
            win_time[slot] = stamp;
            win_val[slot] = enroute;
            if (fill_cnt >= ws) begin
                if (!ref_valid) begin
                    mx = 0;
                    for (int k = 0; k < ws; k++)
                        if (int'(win_val[k]) > mx) mx = int'(win_val[k]);
                    ref_level = mx;
                    ref_valid = 1;
                end else if (int'(enroute) > ref_level * satd_pkg::FAST_FAIL_FACTOR) begin
                    sat = 1;
                end
                attempts = attempts + 8'd1;
                if (slope_sign(ws) <= 0) warm = 1;
                else if (attempts == attempt_limit) sat = 1;
            end
            if (sat) res.verdict = satd_pkg::VERDICT_SATURATED;
            else if (warm) res.verdict = satd_pkg::VERDICT_WARMED;
            if (res.verdict != satd_pkg::VERDICT_NONE) stopped = 1;
        end else begin
            flit_acc = total;
        end
        res.done = stopped;
        return res;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic void add_beat(logic [15:0] flits, logic [31:0] stamp,
                                     logic [23:0] enroute);
        t_job j;
        j = '{default: '0};
        if ($urandom_range(0, 40) == 0) burst_tx = !burst_tx;
        j.flits = flits;
        j.stamp = stamp;
        j.enroute = enroute;
        j.gap = draw_gap(burst_tx);
        jobs.insert(jobs.size(), j);
    endfunction

    // Rising trend: times and in-flight counts both climb, so every pair in
    // the window contributes a positive term and the detector keeps running.
    function automatic void add_trend(logic [15:0] flits);
        trend_k++;
        add_beat(flits, 32'(1000 * trend_k + $urandom_range(0, 500)),
                 24'(100000 + 100 * trend_k + $urandom_range(0, 50)));
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [15:0] data, bit rel);
        t_job j;
        j = '{default: '0};
        j.is_cfg = 1;
        j.idx = idx;
        j.data = data;
        j.rel_limit = rel;
        jobs.insert(jobs.size(), j);
    endfunction

    function automatic void add_pause();
        t_job j;
        j = '{default: '0};
        j.is_cfg = 1;
        j.no_write = 1;
        jobs.insert(jobs.size(), j);
    endfunction

    // Driver.
    t_job cur_job;
    int   gap_left = 0;
    int   idle_run = 0;
    always @(posedge i_clk) begin
        bit         nxt_valid;
        bit         nxt_we;
        logic [1:0] nxt_idx;
        logic [15:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_we = 0;
        nxt_idx = cfg_index;
        nxt_data = cfg_data;
        if (!i_rst_n) begin
            nxt_valid = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                verdicts_due.insert(verdicts_due.size(),
                                    detector_step(cur_job.flits, cur_job.stamp,
                                                  cur_job.enroute));
                nxt_valid = 0;
            end
            if (verdicts_due.size() == 0 && !s_tvalid) idle_run++;
            else idle_run = 0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (jobs.size() > 0) begin
                    if (jobs[0].is_cfg) begin
                        if (idle_run >= SETTLE_CYCLES) begin
                            if (!jobs[0].no_write) begin
                                nxt_we = 1;
                                nxt_idx = jobs[0].idx;
                                nxt_data = jobs[0].data;
                                if (jobs[0].rel_limit)
                                    nxt_data = 16'(attempts + jobs[0].data[7:0]);
                                case (nxt_idx)
                                    satd_pkg::CFG_FLIT_INTERVAL: flit_interval = nxt_data;
                                    satd_pkg::CFG_WINDOW_SIZE:   window_size = nxt_data[6:0];
                                    satd_pkg::CFG_ATTEMPT_LIMIT: attempt_limit = nxt_data[7:0];
                                    default: ;
                                endcase
                            end
                            void'(jobs.pop_front());
                            idle_run = 0;
                        end
                    end else if (jobs[0].gap > 0) begin
                        gap_left = jobs[0].gap - 1;
                        jobs[0].gap = 0;
                    end else begin
                        cur_job = jobs.pop_front();
                        s_tdata <= {cur_job.enroute, cur_job.stamp, cur_job.flits};
                        nxt_valid = 1;
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
        cfg_we <= nxt_we;
        cfg_index <= nxt_idx;
        cfg_data <= nxt_data;
    end

    // Monitor.
    int hold_left = 0;
    int beats_seen = 0;
    always @(posedge i_clk) begin
        t_outcome want;
        bit nxt_ready;
        nxt_ready = 0;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                beats_seen++;
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", o_m_tdata);
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"beat %0d: verdict %0d/%0d taken %0d/%0d",
                                      " done %0d/%0d pad %h"},
                                     beats_seen, want.verdict, o_m_tdata[1:0], want.taken,
                                     o_m_tdata[2], want.done, o_m_tdata[3], o_m_tdata[7:4]);
                    end
                end
                if ($urandom_range(0, 40) == 0) burst_rx = !burst_rx;
                // One long hold lets the detector fill up and back-pressure the source.
                hold_left = (beats_seen == LONG_HOLD_AT) ? LONG_HOLD : draw_gap(burst_rx);
            end
            if (hold_left > 0) hold_left--;
            else nxt_ready = 1;
        end
        m_tready <= nxt_ready;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        // Reset values: 1023 flits stay below the interval, the next one samples.
        add_trend(16'd0);
        add_trend(16'd1000);
        add_trend(16'd23);
        add_trend(16'd1);
        add_trend(16'hFFFF);
        add_pause();
        add_cfg(satd_pkg::CFG_FLIT_INTERVAL, 16'd0, 0);
        add_cfg(satd_pkg::CFG_WINDOW_SIZE, 16'd5, 0);
        add_cfg(satd_pkg::CFG_ATTEMPT_LIMIT, 16'd0, 1);
        repeat (150) add_trend(16'($urandom_range(0, 2)));
        add_cfg(satd_pkg::CFG_FLIT_INTERVAL, 16'hFFFF, 0);
        add_cfg(satd_pkg::CFG_WINDOW_SIZE, 16'd100, 0);
        add_cfg(satd_pkg::CFG_ATTEMPT_LIMIT, 16'd0, 1);
        repeat (150) add_trend(16'($urandom()));
        add_cfg(satd_pkg::CFG_FLIT_INTERVAL, 16'd3, 0);
        add_cfg(satd_pkg::CFG_WINDOW_SIZE, 16'd64, 0);
        repeat (150) add_trend(16'($urandom_range(0, 5)));
        add_cfg(satd_pkg::CFG_FLIT_INTERVAL, 16'($urandom_range(1, 200)), 0);
        add_cfg(satd_pkg::CFG_WINDOW_SIZE, 16'd7, 0);
        add_cfg(satd_pkg::CFG_ATTEMPT_LIMIT, 16'd0, 1);
        repeat (150) add_trend(16'($urandom_range(0, 300)));
        // Single-entry window and arbitrary fields: ends in a verdict, after
        // which the detector only reports that it is done.
        add_cfg(satd_pkg::CFG_FLIT_INTERVAL, 16'd1, 0);
        add_cfg(satd_pkg::CFG_WINDOW_SIZE, 16'd0, 0);
        add_cfg(satd_pkg::CFG_ATTEMPT_LIMIT, 16'd1, 1);
        add_beat(16'd5, 32'hFFFF_FFFF, 24'hFF_FFFF);
        repeat (200) add_beat(16'($urandom()), $urandom(), 24'($urandom()));
        add_cfg(satd_pkg::CFG_FLIT_INTERVAL, 16'hFFFF, 0);
        add_cfg(satd_pkg::CFG_WINDOW_SIZE, 16'd127, 0);
        add_cfg(satd_pkg::CFG_ATTEMPT_LIMIT, 16'd255, 0);
        repeat (100) add_beat(16'($urandom()), $urandom(), 24'($urandom()));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (jobs.size() > 0 || s_tvalid || verdicts_due.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
